// ----- sv/sama_pkg.sv -----
`default_nettype none

package sama_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned NumLanes = 6;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    sample_t accel_x;
    sample_t accel_y;
    sample_t accel_z;
    sample_t gyro_x;
    sample_t gyro_y;
    sample_t gyro_z;
    sample_t mag_x;
    sample_t mag_y;
    sample_t mag_z;
  } in_beat_t;

  typedef struct packed {
    sample_t avg_accel_x;
    sample_t avg_accel_y;
    sample_t avg_accel_z;
    sample_t avg_gyro_x;
    sample_t avg_gyro_y;
    sample_t avg_gyro_z;
    sample_t out_mag_x;
    sample_t out_mag_y;
    sample_t out_mag_z;
  } out_beat_t;

  // Load strobes for the three pipeline stages, shared by every lane.
  typedef struct packed {
    logic ld_sum;
    logic ld_prod;
    logic ld_out;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- sv/sama_lane.sv -----
`default_nettype none

module sama_lane #(
  parameter int unsigned WINDOW = 8,
  parameter int unsigned SumW   = 19
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sama_pkg::pipe_ctl_t  ctl_i,
  input  wire sama_pkg::sample_t    sample_i,
  output logic signed [SumW-1:0]    sum_o
);

  sama_pkg::sample_t         tap_q [WINDOW];
  logic signed [SumW-1:0]    sum_q;
  logic signed [SumW-1:0]    sum_d;

  // The running sum adds the newest sample and drops the one leaving the window.
  // Wrap-around in SumW bits is harmless as the true sum always fits.
  assign sum_d = sum_q + SumW'(sample_i) - SumW'(tap_q[WINDOW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        tap_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (ctl_i.ld_sum) begin
      tap_q[0] <= sample_i;
      for (int i = 1; i < WINDOW; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ----- sv/sama_div.sv -----
`default_nettype none

module sama_div #(
  parameter int unsigned WINDOW = 8,
  parameter int unsigned SumW   = 19
) (
  input  wire logic                 clk_i,
  input  wire sama_pkg::pipe_ctl_t  ctl_i,
  input  wire logic signed [SumW-1:0] sum_i,
  output sama_pkg::sample_t         avg_o
);

  // Exact reciprocal: for any magnitude below 2**SumW, (n * Recip) >> Shift
  // equals floor(n / WINDOW).
  localparam int unsigned Shift  = SumW + $clog2(WINDOW);
  localparam int unsigned RecipW = SumW + 1;
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << Shift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [SumW-1:0]          mag;
  logic [ProdW-1:0]         prod_d;
  logic [ProdW-1:0]         prod_q;
  logic                     neg_q;
  logic [sama_pkg::SampleW-1:0] quot;
  sama_pkg::sample_t        avg_d;
  sama_pkg::sample_t        avg_q;

  assign mag    = sum_i[SumW-1] ? SumW'(-sum_i) : SumW'(sum_i);
  assign prod_d = ProdW'(mag) * ProdW'(Recip);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_prod) begin
      prod_q <= prod_d;
      neg_q  <= sum_i[SumW-1];
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign.
  assign quot  = prod_q[Shift +: sama_pkg::SampleW];
  assign avg_d = neg_q ? sama_pkg::sample_t'(-quot) : sama_pkg::sample_t'(quot);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_out) begin
      avg_q <= avg_d;
    end
  end

  assign avg_o = avg_q;

endmodule

`default_nettype wire

// ----- sv/six_axis_moving_average_unit.sv -----
// A result passes the running sum, the reciprocal product and the output register before it is shown on the output.
// Throughput: one beat per cycle; a new beat is taken every cycle while the output flows.
// The rate is set by the per-lane running sum, which takes one sample per clock unless the pipeline stalls.
// Reset (rst_ni low, asynchronous) clears every window tap and running sum to zero
// and empties the pipeline; no clearing pass follows, the block is ready at once.
`default_nettype none

module six_axis_moving_average_unit #(
  parameter int unsigned WINDOW = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sama_pkg::in_beat_t in_beat_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sama_pkg::out_beat_t     out_beat_o
);

  // Width of a window sum: WINDOW samples of 16 bits need log2(WINDOW) more bits.
  localparam int unsigned SumW = sama_pkg::SampleW + $clog2(WINDOW);

  // Three stages: running sum, reciprocal product, output register.  Each stage
  // takes a new beat when it is empty or when the stage after it moves on.
  logic                valid_sum_q, valid_prod_q, valid_out_q;
  logic                rdy_sum, rdy_prod, rdy_out;
  sama_pkg::pipe_ctl_t ctl;

  assign rdy_out  = !valid_out_q || !out_stall_i;
  assign rdy_prod = !valid_prod_q || rdy_out;
  assign rdy_sum  = !valid_sum_q || rdy_prod;

  assign ctl.ld_sum  = in_valid_i && rdy_sum;
  assign ctl.ld_prod = valid_sum_q && rdy_prod;
  assign ctl.ld_out  = valid_prod_q && rdy_out;

  assign in_stall_o  = !rdy_sum;
  assign out_valid_o = valid_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_sum_q  <= 1'b0;
      valid_prod_q <= 1'b0;
      valid_out_q  <= 1'b0;
    end else begin
      if (rdy_sum) begin
        valid_sum_q <= in_valid_i;
      end
      if (rdy_prod) begin
        valid_prod_q <= valid_sum_q;
      end
      if (rdy_out) begin
        valid_out_q <= valid_prod_q;
      end
    end
  end

  // Six identical lanes, one for each accelerometer and gyroscope axis, in
  // the order of the beat's fields.
  sama_pkg::sample_t lane_in  [sama_pkg::NumLanes];
  sama_pkg::sample_t lane_avg [sama_pkg::NumLanes];

  assign lane_in[0] = in_beat_i.accel_x;
  assign lane_in[1] = in_beat_i.accel_y;
  assign lane_in[2] = in_beat_i.accel_z;
  assign lane_in[3] = in_beat_i.gyro_x;
  assign lane_in[4] = in_beat_i.gyro_y;
  assign lane_in[5] = in_beat_i.gyro_z;

  for (genvar g = 0; g < sama_pkg::NumLanes; g++) begin : g_lane
    logic signed [SumW-1:0] lane_sum;

    sama_lane #(
      .WINDOW (WINDOW),
      .SumW   (SumW)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .sample_i (lane_in[g]),
      .sum_o    (lane_sum)
    );

    sama_div #(
      .WINDOW (WINDOW),
      .SumW   (SumW)
    ) u_div (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .sum_i (lane_sum),
      .avg_o (lane_avg[g])
    );
  end

  // The magnetometer axes travel alongside the lanes, one register per stage,
  // so that they leave with the averages of the same beat.
  sama_pkg::sample_t mag_sum_q  [3];
  sama_pkg::sample_t mag_prod_q [3];
  sama_pkg::sample_t mag_out_q  [3];

  always_ff @(posedge clk_i) begin
    if (ctl.ld_sum) begin
      mag_sum_q[0] <= in_beat_i.mag_x;
      mag_sum_q[1] <= in_beat_i.mag_y;
      mag_sum_q[2] <= in_beat_i.mag_z;
    end
    if (ctl.ld_prod) begin
      mag_prod_q <= mag_sum_q;
    end
    if (ctl.ld_out) begin
      mag_out_q <= mag_prod_q;
    end
  end

  // Merge the lane results and the magnetometer values into the output beat.
  always_comb begin
    out_beat_o.avg_accel_x = lane_avg[0];
    out_beat_o.avg_accel_y = lane_avg[1];
    out_beat_o.avg_accel_z = lane_avg[2];
    out_beat_o.avg_gyro_x  = lane_avg[3];
    out_beat_o.avg_gyro_y  = lane_avg[4];
    out_beat_o.avg_gyro_z  = lane_avg[5];
    out_beat_o.out_mag_x   = mag_out_q[0];
    out_beat_o.out_mag_y   = mag_out_q[1];
    out_beat_o.out_mag_z   = mag_out_q[2];
  end

endmodule

`default_nettype wire

// ----- sv/sama_chk.sv -----
`default_nettype none

module sama_chk (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire sama_pkg::out_beat_t out_beat_o
);

  logic       in_acc, out_acc;
  logic [2:0] occ_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Beats accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled output beat changed");

  // The input is only held back when the output itself is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // The pipeline never holds more than its three stages.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 3'd3)
    else $error("more beats in flight than stages");

  // No result appears without an accepted beat behind it.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == 3'd0 |-> !out_valid_o)
    else $error("output beat without accepted input");

  // The input is taken freely while the pipeline is not full.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q < 3'd3 |-> !in_stall_o)
    else $error("input stalled while pipeline has room");

endmodule

bind six_axis_moving_average_unit sama_chk u_sama_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

`default_nettype wire
